### hdl/spfc_pkg.sv
// Shared types and constants for the sensor packet framer and reply checker.
// Used by spfc_front, spfc_queue, spfc_back and the top level; no dependencies.
package spfc_pkg;

    localparam int unsigned MAX_PAYLOAD = 20;

    localparam logic [1:0] KIND_BEGIN   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_RX      = 2'd2;

    localparam logic [1:0] OUT_TX     = 2'd0;
    localparam logic [1:0] OUT_BODY   = 2'd1;
    localparam logic [1:0] OUT_STATUS = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DEV_ERR   = 3'd1;
    localparam logic [2:0] ST_BAD_HDR   = 3'd2;
    localparam logic [2:0] ST_BAD_LEN   = 3'd3;
    localparam logic [2:0] ST_BAD_CHECK = 3'd4;

    localparam logic [7:0] START_HI  = 8'hef;
    localparam logic [7:0] START_LO  = 8'h01;
    localparam logic [7:0] ADDR_BYTE = 8'hff;
    localparam logic [7:0] PID_CMD   = 8'h01;
    localparam logic [7:0] PID_ACK   = 8'h07;

    localparam logic [6:0] MAX_BODY_RESET = 7'd32;

    // Transmit steps: start bytes, address bytes, packet id, length, data, then the two checksum bytes.
    localparam logic [3:0] STEP_FIRST      = 4'd0;
    localparam logic [3:0] STEP_START_LO   = 4'd1;
    localparam logic [3:0] STEP_ADDR_FIRST = 4'd2;
    localparam logic [3:0] STEP_ADDR_LAST  = 4'd5;
    localparam logic [3:0] STEP_PID        = 4'd6;
    localparam logic [3:0] STEP_LEN_HI     = 4'd7;
    localparam logic [3:0] STEP_LEN_LO     = 4'd8;
    localparam logic [3:0] STEP_DATA       = 4'd9;
    localparam logic [3:0] STEP_SUM_HI     = 4'd10;
    localparam logic [3:0] STEP_SUM_LO     = 4'd11;

    typedef enum logic [1:0] {
        OP_TX     = 2'd0,
        OP_BODY   = 2'd1,
        OP_STATUS = 2'd2
    } job_op_t;

    typedef struct packed {
        job_op_t     op;
        logic [3:0]  start;
        logic [7:0]  data;
        logic [7:0]  len;
        logic [15:0] sum;
        logic        add_sum;
        logic [2:0]  status;
        logic [6:0]  blen;
    } job_t;

    typedef enum logic [9:0] {
        RX_IDLE = 10'b00_0000_0001,
        RX_S0   = 10'b00_0000_0010,
        RX_S1   = 10'b00_0000_0100,
        RX_ADDR = 10'b00_0000_1000,
        RX_PID  = 10'b00_0001_0000,
        RX_LENH = 10'b00_0010_0000,
        RX_LENL = 10'b00_0100_0000,
        RX_BODY = 10'b00_1000_0000,
        RX_CHKH = 10'b01_0000_0000,
        RX_CHKL = 10'b10_0000_0000
    } rx_state_t;

    function automatic logic [7:0] tx_byte(input logic [3:0] step, input job_t job);
        logic [7:0] b;
        b = 8'h00;
        unique case (step) inside
            STEP_FIRST:                       b = START_HI;
            STEP_START_LO:                    b = START_LO;
            [STEP_ADDR_FIRST:STEP_ADDR_LAST]: b = ADDR_BYTE;
            STEP_PID:                         b = PID_CMD;
            STEP_LEN_HI:                      b = 8'h00;
            STEP_LEN_LO:                      b = job.len;
            STEP_DATA:                        b = job.data;
            STEP_SUM_HI:                      b = job.sum[15:8];
            STEP_SUM_LO:                      b = job.sum[7:0];
            default:                          b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### hdl/spfc_front.sv
// Front end: accepts input transactions, keeps transmit and receive state,
// and turns each transaction into at most one job. Depends on spfc_pkg.
module spfc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_wdata,
    input  logic                accept,
    input  logic [1:0]          in_kind,
    input  logic [7:0]          in_value,
    input  logic [4:0]          in_count,
    output logic                push,
    output spfc_pkg::job_t      push_job
);

    logic [6:0]          max_body_len_reg;
    logic [4:0]          tx_rem_reg, tx_rem_next;
    logic [15:0]         tx_sum_reg, tx_sum_next;
    spfc_pkg::rx_state_t rx_state_reg, rx_state_next;
    logic [6:0]          rx_index_reg, rx_index_next;
    logic [7:0]          rx_len_hi_reg, rx_len_hi_next;
    logic [6:0]          rx_body_reg, rx_body_next;
    logic [15:0]         rx_sum_reg, rx_sum_next;
    logic                rx_confirm_reg, rx_confirm_next;
    logic [7:0]          rx_check_hi_reg, rx_check_hi_next;

    logic [7:0]  tx_len;
    logic [15:0] rx_len16;
    logic [15:0] rx_body16;
    logic [6:0]  rx_index_inc;
    logic [15:0] rx_sum_add;
    logic [15:0] tx_sum_add;

    assign tx_len       = 8'(in_count) + 8'd3;
    assign rx_len16     = {rx_len_hi_reg, in_value};
    assign rx_body16    = rx_len16 - 16'd2;
    assign rx_index_inc = rx_index_reg + 7'd1;
    assign rx_sum_add   = rx_sum_reg + 16'(in_value);
    assign tx_sum_add   = tx_sum_reg + 16'(in_value);

    always_comb
    begin
        tx_rem_next      = tx_rem_reg;
        tx_sum_next      = tx_sum_reg;
        rx_state_next    = rx_state_reg;
        rx_index_next    = rx_index_reg;
        rx_len_hi_next   = rx_len_hi_reg;
        rx_body_next     = rx_body_reg;
        rx_sum_next      = rx_sum_reg;
        rx_confirm_next  = rx_confirm_reg;
        rx_check_hi_next = rx_check_hi_reg;
        push             = 1'b0;
        push_job         = '0;
        push_job.op      = spfc_pkg::OP_TX;

        if (accept)
        begin
            unique case (in_kind)
                spfc_pkg::KIND_BEGIN:
                begin
                    tx_rem_next = '0;
                    if (6'(in_count) <= 6'(spfc_pkg::MAX_PAYLOAD))
                    begin
                        tx_sum_next      = 16'd1 + 16'(tx_len) + 16'(in_value);
                        tx_rem_next      = in_count;
                        push             = 1'b1;
                        push_job.op      = spfc_pkg::OP_TX;
                        push_job.start   = spfc_pkg::STEP_FIRST;
                        push_job.data    = in_value;
                        push_job.len     = tx_len;
                        push_job.sum     = tx_sum_next;
                        push_job.add_sum = (in_count == 5'd0);
                        rx_state_next    = spfc_pkg::RX_S0;
                        rx_index_next    = '0;
                        rx_len_hi_next   = '0;
                        rx_body_next     = '0;
                        rx_sum_next      = '0;
                        rx_confirm_next  = 1'b0;
                        rx_check_hi_next = '0;
                    end
                end
                spfc_pkg::KIND_PAYLOAD:
                begin
                    if (tx_rem_reg != 5'd0)
                    begin
                        tx_sum_next      = tx_sum_add;
                        tx_rem_next      = tx_rem_reg - 5'd1;
                        push             = 1'b1;
                        push_job.op      = spfc_pkg::OP_TX;
                        push_job.start   = spfc_pkg::STEP_DATA;
                        push_job.data    = in_value;
                        push_job.sum     = tx_sum_add;
                        push_job.add_sum = (tx_rem_reg == 5'd1);
                    end
                end
                spfc_pkg::KIND_RX:
                begin
                    unique case (rx_state_reg)
                        spfc_pkg::RX_S0:
                        begin
                            if (in_value != spfc_pkg::START_HI)
                            begin
                                rx_state_next   = spfc_pkg::RX_IDLE;
                                push            = 1'b1;
                                push_job.op     = spfc_pkg::OP_STATUS;
                                push_job.status = spfc_pkg::ST_BAD_HDR;
                            end
                            else
                            begin
                                rx_state_next = spfc_pkg::RX_S1;
                            end
                        end
                        spfc_pkg::RX_S1:
                        begin
                            if (in_value != spfc_pkg::START_LO)
                            begin
                                rx_state_next   = spfc_pkg::RX_IDLE;
                                push            = 1'b1;
                                push_job.op     = spfc_pkg::OP_STATUS;
                                push_job.status = spfc_pkg::ST_BAD_HDR;
                            end
                            else
                            begin
                                rx_state_next = spfc_pkg::RX_ADDR;
                                rx_index_next = '0;
                            end
                        end
                        spfc_pkg::RX_ADDR:
                        begin
                            rx_index_next = rx_index_inc;
                            if (rx_index_inc >= 7'd4)
                            begin
                                rx_state_next = spfc_pkg::RX_PID;
                            end
                        end
                        spfc_pkg::RX_PID:
                        begin
                            if (in_value != spfc_pkg::PID_ACK)
                            begin
                                rx_state_next   = spfc_pkg::RX_IDLE;
                                push            = 1'b1;
                                push_job.op     = spfc_pkg::OP_STATUS;
                                push_job.status = spfc_pkg::ST_BAD_HDR;
                            end
                            else
                            begin
                                rx_sum_next   = 16'(in_value);
                                rx_state_next = spfc_pkg::RX_LENH;
                            end
                        end
                        spfc_pkg::RX_LENH:
                        begin
                            rx_len_hi_next = in_value;
                            rx_sum_next    = rx_sum_add;
                            rx_state_next  = spfc_pkg::RX_LENL;
                        end
                        spfc_pkg::RX_LENL:
                        begin
                            rx_sum_next = rx_sum_add;
                            if ((rx_len16 < 16'd3) || (rx_body16 > 16'(max_body_len_reg)))
                            begin
                                rx_state_next   = spfc_pkg::RX_IDLE;
                                push            = 1'b1;
                                push_job.op     = spfc_pkg::OP_STATUS;
                                push_job.status = spfc_pkg::ST_BAD_LEN;
                            end
                            else
                            begin
                                rx_body_next  = rx_body16[6:0];
                                rx_index_next = '0;
                                rx_state_next = spfc_pkg::RX_BODY;
                            end
                        end
                        spfc_pkg::RX_BODY:
                        begin
                            if (rx_index_reg == 7'd0)
                            begin
                                rx_confirm_next = (in_value != 8'h00);
                            end
                            rx_sum_next   = rx_sum_add;
                            rx_index_next = rx_index_inc;
                            if (rx_index_inc >= rx_body_reg)
                            begin
                                rx_state_next = spfc_pkg::RX_CHKH;
                            end
                            push          = 1'b1;
                            push_job.op   = spfc_pkg::OP_BODY;
                            push_job.data = in_value;
                        end
                        spfc_pkg::RX_CHKH:
                        begin
                            rx_check_hi_next = in_value;
                            rx_state_next    = spfc_pkg::RX_CHKL;
                        end
                        spfc_pkg::RX_CHKL:
                        begin
                            rx_state_next = spfc_pkg::RX_IDLE;
                            push          = 1'b1;
                            push_job.op   = spfc_pkg::OP_STATUS;
                            push_job.blen = rx_body_reg;
                            if ({rx_check_hi_reg, in_value} != rx_sum_reg)
                            begin
                                push_job.status = spfc_pkg::ST_BAD_CHECK;
                            end
                            else if (rx_confirm_reg)
                            begin
                                push_job.status = spfc_pkg::ST_DEV_ERR;
                            end
                            else
                            begin
                                push_job.status = spfc_pkg::ST_OK;
                            end
                        end
                        default:
                        begin
                            rx_state_next = spfc_pkg::RX_IDLE;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_body_len_reg <= spfc_pkg::MAX_BODY_RESET;
            tx_rem_reg       <= '0;
            tx_sum_reg       <= '0;
            rx_state_reg     <= spfc_pkg::RX_IDLE;
            rx_index_reg     <= '0;
            rx_len_hi_reg    <= '0;
            rx_body_reg      <= '0;
            rx_sum_reg       <= '0;
            rx_confirm_reg   <= 1'b0;
            rx_check_hi_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_body_len_reg <= cfg_wdata;
            end
            tx_rem_reg      <= tx_rem_next;
            tx_sum_reg      <= tx_sum_next;
            rx_state_reg    <= rx_state_next;
            rx_index_reg    <= rx_index_next;
            rx_len_hi_reg   <= rx_len_hi_next;
            rx_body_reg     <= rx_body_next;
            rx_sum_reg      <= rx_sum_next;
            rx_confirm_reg  <= rx_confirm_next;
            rx_check_hi_reg <= rx_check_hi_next;
        end
    end

endmodule

### hdl/spfc_queue.sv
// Short job queue between the front end and the back end.
// Depends on spfc_pkg for the job type.
module spfc_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  spfc_pkg::job_t push_job,
    input  logic           pop,
    output spfc_pkg::job_t head,
    output logic           full,
    output logic           empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    spfc_pkg::job_t  mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hdl/spfc_back.sv
// Back end: expands queued jobs into result transactions, one per cycle unless the
// output stalls, through a registered output stage. Depends on spfc_pkg.
module spfc_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  spfc_pkg::job_t head,
    input  logic           empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     out_kind,
    output logic [7:0]     out_byte,
    output logic [2:0]     out_status,
    output logic [6:0]     out_blen,
    output logic           out_last
);

    logic       valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg;
    logic [2:0] status_reg;
    logic [6:0] blen_reg;
    logic       last_reg;
    logic       active_reg;
    logic [3:0] step_reg;

    logic       load;
    logic [3:0] step;
    logic [1:0] r_kind;
    logic [7:0] r_byte;
    logic [2:0] r_status;
    logic [6:0] r_blen;
    logic       r_last;

    assign load = !empty && (!valid_reg || out_ready);
    assign step = active_reg ? step_reg : head.start;
    assign pop  = load && r_last;

    always_comb
    begin
        r_kind   = spfc_pkg::OUT_TX;
        r_byte   = 8'h00;
        r_status = spfc_pkg::ST_OK;
        r_blen   = '0;
        r_last   = 1'b1;
        unique case (head.op)
            spfc_pkg::OP_TX:
            begin
                r_byte = spfc_pkg::tx_byte(step, head);
                r_last = (step == spfc_pkg::STEP_SUM_LO) ||
                         ((step == spfc_pkg::STEP_DATA) && !head.add_sum);
            end
            spfc_pkg::OP_BODY:
            begin
                r_kind = spfc_pkg::OUT_BODY;
                r_byte = head.data;
            end
            spfc_pkg::OP_STATUS:
            begin
                r_kind   = spfc_pkg::OUT_STATUS;
                r_status = head.status;
                r_blen   = head.blen;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= r_kind;
            byte_reg   <= r_byte;
            status_reg <= r_status;
            blen_reg   <= r_blen;
            last_reg   <= r_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            active_reg <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg  <= 1'b1;
                active_reg <= !r_last;
                step_reg   <= step + 4'd1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = valid_reg;
    assign out_kind   = kind_reg;
    assign out_byte   = byte_reg;
    assign out_status = status_reg;
    assign out_blen   = blen_reg;
    assign out_last   = last_reg;

endmodule

### hdl/sensor_packet_framer_checker.sv
// Top level of the sensor packet framer and reply checker.
// Depends on spfc_pkg, spfc_front, spfc_queue and spfc_back.
//
// Channel  | Direction | tdata                                   | tuser      | tlast
// s_axis   | in        | [7:0] value, [12:8] payload_count       | [1:0] kind | -
// m_axis   | out       | [7:0] byte_out, [10:8] status,          | [1:0]      | last
//          |           | [17:11] body_length                     | out_kind   |
// cfg      | in        | cfg_wdata = max_body_len on cfg_we      | -          | -
//
// The front end takes one input transaction per cycle while the job queue has room.
// Without output stalls the back end emits one result per cycle: a begin job gives 10 or
// 12 results, a payload job 1 or 3, a body byte or end status 1; the back end sets the
// sustained rate in bursts of begin items. Output stalls fill the queue, then stall input.
// Reset is asynchronous and clears all control state; no clearing pass is needed.
module sensor_packet_framer_checker
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // value, payload_count
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // byte_out, status, body_length
    output logic [1:0]  m_axis_tuser,   // out_kind
    output logic        m_axis_tlast
);

    logic           accept;
    logic           push;
    spfc_pkg::job_t push_job;
    logic           pop;
    spfc_pkg::job_t head;
    logic           q_full;
    logic           q_empty;
    logic [7:0]     out_byte;
    logic [2:0]     out_status;
    logic [6:0]     out_blen;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    spfc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_kind   (s_axis_tuser),
        .in_value  (s_axis_tdata[7:0]),
        .in_count  (s_axis_tdata[12:8]),
        .push      (push),
        .push_job  (push_job)
    );

    spfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    spfc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (q_empty),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_kind   (m_axis_tuser),
        .out_byte   (out_byte),
        .out_status (out_status),
        .out_blen   (out_blen),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, out_blen, out_status, out_byte};

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_full)
        else $error("Job pushed into a full queue.");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_empty)
        else $error("Job popped from an empty queue.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != spfc_pkg::OUT_STATUS))
            |-> (m_axis_tdata[17:8] == 10'd0))
        else $error("Byte result carries a status or body length.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == spfc_pkg::OUT_STATUS)) |-> m_axis_tlast)
        else $error("End status transaction without tlast.");
`endif

endmodule
